// ===== design/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, constants, status codes and request decode type for the
// bump slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int unsigned SIZE_W       = 20;
  localparam int unsigned PG_W         = 5;
  localparam int unsigned SLOT_PORT_W  = 2;
  localparam int unsigned STATUS_W     = 3;

  localparam int unsigned REGION_PAGES = 16;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int unsigned REGION_BYTES = REGION_PAGES * PAGE_BYTES;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVE_BAD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PUT_UNUSED  = 3'd5;

  typedef struct packed {
    logic                err;
    logic [STATUS_W-1:0] err_status;
    logic [PG_W-1:0]     pages;
    logic [PG_W-1:0]     limit;
  } req_dec_t;

endpackage

// ===== design/bsa_ram.sv =====
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bsa_req_decode.sv =====
// ----------------------------------------------------------------------------
// bsa_req_decode
// Checks a get request against the region, rounds its size to pages and
// selects the usable page limit.
// ----------------------------------------------------------------------------
module bsa_req_decode (
  input  logic [bsa_pkg::SIZE_W-1:0] size_bytes,
  input  logic                       reserve,
  output bsa_pkg::req_dec_t          dec
);

  localparam int unsigned RW = bsa_pkg::SIZE_W + 1;

  logic [RW-1:0] rounded;
  logic [RW-1:0] pages_full;
  logic          too_large;
  logic          reserve_bad;

  always_comb begin
    too_large   = RW'(size_bytes) > RW'(bsa_pkg::REGION_BYTES);
    rounded     = RW'(size_bytes) + RW'(bsa_pkg::PAGE_BYTES - 1);
    pages_full  = rounded >> bsa_pkg::PAGE_SHIFT;
    dec.pages   = pages_full[bsa_pkg::PG_W-1:0];
    reserve_bad = reserve && (pages_full != RW'(1));
    dec.err     = too_large || reserve_bad;
    dec.err_status = too_large ? bsa_pkg::ST_TOO_LARGE : bsa_pkg::ST_RESERVE_BAD;
    dec.limit   = reserve ? bsa_pkg::PG_W'(bsa_pkg::REGION_PAGES)
                          : bsa_pkg::PG_W'(bsa_pkg::REGION_PAGES - 1);
  end

endmodule

// ===== design/bump_slot_allocator_lazy_flush_unit.sv =====
// sequence: a put or rejected get is answered straight from IDLE, a get that fits
// goes through COMMIT, a get that wraps the pointer goes through SCAN, CHECK and
// COMMIT, or ends at CHECK when it finds no space (one slot ram read per cycle)
// throughput: one word at a time, next word taken once the sequencer is idle
// and the result register is free or being drained
// reset: bump pointer to region start, all slots free, slot ram left undefined
// ----------------------------------------------------------------------------
// bump_slot_allocator_lazy_flush_unit
// In-order page bump allocator with tracking slots; slot extents live in a
// small ram, a wrapping get scans it for the highest end still in use.
// ----------------------------------------------------------------------------
module bump_slot_allocator_lazy_flush_unit #(
  parameter int unsigned SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic                             kind,
  input  logic [bsa_pkg::SIZE_W-1:0]       size_bytes,
  input  logic                             reserve,
  input  logic [bsa_pkg::SLOT_PORT_W-1:0]  slot,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic [bsa_pkg::STATUS_W-1:0]     status,
  output logic [bsa_pkg::SLOT_PORT_W-1:0]  slot_index,
  output logic [bsa_pkg::PG_W-1:0]         base_page,
  output logic [bsa_pkg::PG_W-1:0]         page_count,
  output logic                             flush_done
);

  localparam int unsigned PG_W   = bsa_pkg::PG_W;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = SLOT_W + 1;
  localparam int unsigned RAM_W  = 2 * PG_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_CHECK  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t              state;
  logic [SLOTS-1:0]    used;
  logic [PG_W-1:0]     next_page;
  logic [PG_W-1:0]     pages_r;
  logic [PG_W-1:0]     limit_r;
  logic [PG_W-1:0]     low;
  logic                flush;
  logic [CNT_W-1:0]    cnt;
  logic                pend;
  logic [SLOT_W-1:0]   pidx;

  bsa_pkg::req_dec_t   dec;
  logic                out_free;
  logic                accept;
  logic                need_wrap;
  logic                put_hit;
  logic                scan_issue;
  logic                check_fail;
  logic                rsp_load;
  logic                found;
  logic [SLOT_W-1:0]   pick;
  logic                ram_we;
  logic [RAM_W-1:0]    ram_wdata;
  logic [RAM_W-1:0]    ram_rdata;
  logic [PG_W-1:0]     rd_end;
  logic [PG_W-1:0]     grant_end;

  bsa_req_decode u_decode (
    .size_bytes  (size_bytes),
    .reserve     (reserve),
    .dec         (dec)
  );

  bsa_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick),
    .wdata (ram_wdata),
    .raddr (cnt[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_free   = !rsp_valid || rsp_ready;
    req_ready  = (state == S_IDLE) && out_free;
    accept     = req_valid && req_ready;
    need_wrap  = ({1'b0, next_page} + {1'b0, dec.pages}) > {1'b0, dec.limit};
    put_hit    = (int'(slot) < SLOTS) && used[slot[SLOT_W-1:0]];
    scan_issue = (state == S_SCAN) && (cnt < CNT_W'(SLOTS));
    rd_end     = ram_rdata[PG_W-1:0];
    check_fail = (low > limit_r) || (pages_r > (limit_r - low));
    rsp_load   = (accept && ((kind == bsa_pkg::KIND_PUT) || dec.err))
              || ((state == S_CHECK) && check_fail && out_free)
              || ((state == S_COMMIT) && out_free);
    found      = 1'b0;
    pick       = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        pick  = SLOT_W'(i);
      end
    end
    grant_end  = next_page + pages_r;
    ram_we     = (state == S_COMMIT) && out_free && found;
    // base in upper half, end in lower half
    ram_wdata  = {next_page, grant_end};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      used      <= '0;
      next_page <= '0;
      flush     <= 1'b0;
      cnt       <= '0;
      pend      <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == bsa_pkg::KIND_PUT) begin
              status     <= put_hit ? bsa_pkg::ST_OK : bsa_pkg::ST_PUT_UNUSED;
              slot_index <= slot;
              base_page  <= '0;
              page_count <= '0;
              flush_done <= 1'b0;
              if (put_hit) begin
                used[slot[SLOT_W-1:0]] <= 1'b0;
              end
            end else if (dec.err) begin
              status     <= dec.err_status;
              slot_index <= '0;
              base_page  <= '0;
              page_count <= '0;
              flush_done <= 1'b0;
            end else begin
              pages_r <= dec.pages;
              limit_r <= dec.limit;
              flush   <= 1'b0;
              low     <= '0;
              cnt     <= '0;
              pend    <= 1'b0;
              state   <= need_wrap ? S_SCAN : S_COMMIT;
            end
          end
        end
        S_SCAN: begin
          // fold the end read last cycle, issue the next read
          if (pend && used[pidx] && (rd_end > low)) begin
            low <= rd_end;
          end
          pend <= scan_issue;
          if (scan_issue) begin
            pidx <= cnt[SLOT_W-1:0];
            cnt  <= cnt + CNT_W'(1);
          end else if (!pend) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (check_fail) begin
            if (out_free) begin
              status     <= bsa_pkg::ST_NO_SPACE;
              slot_index <= '0;
              base_page  <= '0;
              page_count <= '0;
              flush_done <= 1'b0;
              state      <= S_IDLE;
            end
          end else begin
            next_page <= low;
            flush     <= 1'b1;
            state     <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            flush_done <= flush;
            state      <= S_IDLE;
            if (found) begin
              used[pick] <= 1'b1;
              status     <= bsa_pkg::ST_OK;
              slot_index <= bsa_pkg::SLOT_PORT_W'(pick);
              base_page  <= next_page;
              page_count <= pages_r;
              next_page  <= grant_end;
            end else begin
              status     <= bsa_pkg::ST_NO_SLOT;
              slot_index <= '0;
              base_page  <= '0;
              page_count <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
